// ===== rtl/psc_pkg.sv =====
// shared types, constants and helpers of the progressive shift cipher
`timescale 1ns / 1ps
package psc_pkg;

   localparam int CHAR_W     = 8;
   localparam int LSHIFT_W   = 5;
   localparam int DSHIFT_W   = 4;
   localparam int COUNT_W    = 13;
   localparam int KEY_W      = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int HOLD_DEPTH = 6;
   localparam int FILL_W     = 3;
   localparam int MARK_LEN   = 7;
   localparam int MARK_IDX_W = 3;

   localparam logic [COUNT_W-1:0] MAX_OUT = 13'd4096;

   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'd65;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'd90;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'd97;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'd122;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'd57;
   localparam logic [CHAR_W-1:0] MARK_FILL    = 8'd95;
   localparam logic [CHAR_W-1:0] MARK_E       = 8'd69;
   localparam logic [CHAR_W-1:0] MARK_O       = 8'd79;
   localparam logic [CHAR_W-1:0] MARK_M       = 8'd77;

   localparam logic [5:0] LETTER_COUNT = 6'd26;
   localparam logic [4:0] DIGIT_COUNT  = 5'd10;

   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;
   localparam logic KIND_BYTE    = 1'b0;
   localparam logic KIND_END     = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_ROOM    = 2'd1,
      STATUS_NO_MARKER  = 2'd2
   } status_type;

   typedef struct packed {
      logic [CHAR_W-1:0]  out_char;
      logic               is_final;
      status_type         status;
      logic [COUNT_W-1:0] coded_total;
   } result_type;

   // one result from the datapath; burst starts the marker sequence
   typedef struct packed {
      logic               valid;
      logic               burst;
      logic [COUNT_W-1:0] final_total;
      result_type         res;
   } emit_type;

   typedef struct packed {
      logic [CHAR_W-1:0]   ch;
      logic [LSHIFT_W-1:0] ls;
      logic [DSHIFT_W-1:0] ds;
   } hold_type;

   function automatic logic [CHAR_W-1:0] mark_byte(input logic [MARK_IDX_W-1:0] idx);
      logic [CHAR_W-1:0] b;
      unique case (idx)
         3'd2:    b = MARK_E;
         3'd3:    b = MARK_O;
         3'd4:    b = MARK_M;
         default: b = MARK_FILL;
      endcase
      return b;
   endfunction

endpackage

// ===== rtl/psc_code_unit.sv =====
// shifts one letter or digit forward or back, other bytes pass
`timescale 1ns / 1ps
module psc_code_unit
   import psc_pkg::*;
(
   input  logic [CHAR_W-1:0]   ch,
   input  logic [LSHIFT_W-1:0] ls,
   input  logic [DSHIFT_W-1:0] ds,
   input  logic                decrypt,
   output logic [CHAR_W-1:0]   coded_char,
   output logic                is_coded
);

   logic              is_upper;
   logic              is_lower;
   logic              is_digit;
   logic [CHAR_W-1:0] base;
   logic [4:0]        letter;
   logic [5:0]        lsum;
   logic [4:0]        dsum;

   assign is_upper = (ch >= CHAR_UPPER_A) && (ch <= CHAR_UPPER_Z);
   assign is_lower = (ch >= CHAR_LOWER_A) && (ch <= CHAR_LOWER_Z);
   assign is_digit = (ch >= CHAR_DIGIT_0) && (ch <= CHAR_DIGIT_9);
   assign base     = is_upper ? CHAR_UPPER_A : CHAR_LOWER_A;
   assign letter   = 5'(ch - base);

   always_comb begin
      if (decrypt) begin
         lsum = {1'b0, letter} + LETTER_COUNT - {1'b0, ls};
         dsum = {1'b0, ch[3:0]} + DIGIT_COUNT - {1'b0, ds};
      end else begin
         lsum = {1'b0, letter} + {1'b0, ls};
         dsum = {1'b0, ch[3:0]} + {1'b0, ds};
      end
      if (lsum >= LETTER_COUNT) begin
         lsum = lsum - LETTER_COUNT;
      end
      if (dsum >= DIGIT_COUNT) begin
         dsum = dsum - DIGIT_COUNT;
      end
   end

   always_comb begin
      is_coded = is_upper || is_lower || is_digit;
      if (is_upper || is_lower) begin
         coded_char = base + {2'b00, lsum};
      end else if (is_digit) begin
         coded_char = CHAR_DIGIT_0 + {3'b000, dsum};
      end else begin
         coded_char = ch;
      end
   end

endmodule

// ===== rtl/psc_out_stage.sv =====
// result register with the end-of-message marker sequencer
`timescale 1ns / 1ps
module psc_out_stage
   import psc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  emit_type           emit,
   output logic               take_ok,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CHAR_W-1:0]  rsp_out_char,
   output logic               rsp_is_final,
   output logic [1:0]         rsp_status,
   output logic [COUNT_W-1:0] rsp_coded_total
);

   logic                  rsp_valid_ff;
   result_type            res_ff;
   result_type            res_in;
   logic                  burst_ff;
   logic [MARK_IDX_W-1:0] burst_idx_ff;
   logic [COUNT_W-1:0]    burst_total_ff;
   logic                  out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign take_ok  = out_free && !burst_ff;

   always_comb begin
      res_in             = '0;
      res_in.status      = STATUS_OK;
      if (burst_idx_ff == MARK_IDX_W'(MARK_LEN)) begin
         res_in.is_final    = 1'b1;
         res_in.coded_total = burst_total_ff;
      end else begin
         res_in.out_char = mark_byte(burst_idx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         burst_ff     <= 1'b0;
         burst_idx_ff <= '0;
      end else if (out_free) begin
         if (burst_ff) begin
            rsp_valid_ff <= 1'b1;
            burst_idx_ff <= burst_idx_ff + 1'b1;
            if (burst_idx_ff == MARK_IDX_W'(MARK_LEN)) begin
               burst_ff <= 1'b0;
            end
         end else if (emit.valid) begin
            rsp_valid_ff <= 1'b1;
            burst_ff     <= emit.burst;
            burst_idx_ff <= MARK_IDX_W'(1);
         end else begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (burst_ff) begin
            res_ff <= res_in;
         end else if (emit.valid) begin
            res_ff         <= emit.res;
            burst_total_ff <= emit.final_total;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = res_ff.out_char;
   assign rsp_is_final    = res_ff.is_final;
   assign rsp_status      = res_ff.status;
   assign rsp_coded_total = res_ff.coded_total;

endmodule

// ===== rtl/progressive_shift_cipher_top.sv =====
// Progressive shift cipher: a message byte enters the input register and is coded from
// there into the result register; the block takes one byte transfer per cycle when the
// result side keeps up. An end-of-message item in encrypt mode with room for the marker
// yields eight results (seven marker bytes and the final status item) from the result
// register's sequencer, one per cycle while the result side keeps up, and no new item is
// taken while that runs; every other end-of-message item yields one result. Decrypt holds
// six bytes back in a shift line, so its first six bytes give no result.
`timescale 1ns / 1ps
module progressive_shift_cipher_top
   import psc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [CHAR_W-1:0]     req_ch,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHAR_W-1:0]     rsp_out_char,
   output logic                  rsp_is_final,
   output logic [1:0]            rsp_status,
   output logic [COUNT_W-1:0]    rsp_coded_total
);

   // configuration
   logic                mode_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [COUNT_W-1:0]  limit_ff;

   // input register
   logic                in_valid_ff;
   logic                in_kind_ff;
   logic [CHAR_W-1:0]   in_ch_ff;
   logic                in_advance;
   logic                take_ok;

   // message state
   logic                msg_open_ff,  msg_open_in;
   logic [LSHIFT_W-1:0] ls_ff,        ls_in;
   logic [DSHIFT_W-1:0] ds_ff,        ds_in;
   logic [COUNT_W-1:0]  wc_ff,        wc_in;
   logic [COUNT_W-1:0]  cc_ff,        cc_in;
   logic                full_ff,      full_in;
   logic                seen_ff,      seen_in;
   logic [FILL_W-1:0]   fill_ff,      fill_in;
   hold_type            hold_ff [HOLD_DEPTH];
   hold_type            hold_in [HOLD_DEPTH];

   logic [LSHIFT_W-1:0] key26;
   logic [DSHIFT_W-1:0] key10;
   logic [COUNT_W-1:0]  lim;
   logic                decrypt;
   logic [LSHIFT_W-1:0] cur_ls, ls_next;
   logic [DSHIFT_W-1:0] cur_ds, ds_next;
   logic [COUNT_W-1:0]  cur_wc;
   logic [COUNT_W-1:0]  cur_cc;
   logic                cur_full;
   logic                cur_seen;
   logic [FILL_W-1:0]   cur_fill;
   logic                match;
   hold_type            entry;

   logic [CHAR_W-1:0]   code_ch;
   logic [LSHIFT_W-1:0] code_ls;
   logic [DSHIFT_W-1:0] code_ds;
   logic [CHAR_W-1:0]   coded_char;
   logic                is_coded;
   emit_type            emit;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_ENCRYPT;
         key_ff   <= '0;
         limit_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE:  mode_ff  <= csr_data[0];
            CSR_KEY:   key_ff   <= csr_data[KEY_W-1:0];
            CSR_LIMIT: limit_ff <= csr_data;
            default:   ;
         endcase
      end
   end

   assign in_advance = in_valid_ff && take_ok;
   assign req_ready  = !in_valid_ff || in_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (in_advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_kind_ff <= req_kind;
         in_ch_ff   <= req_ch;
      end
   end

   // key reduced mod 26, digit shift mod 10
   always_comb begin
      key26 = (key_ff >= LETTER_COUNT[LSHIFT_W-1:0]) ? key_ff - LETTER_COUNT[LSHIFT_W-1:0]
                                                    : key_ff;
      if (key26 >= LSHIFT_W'(20)) begin
         key10 = DSHIFT_W'(key26 - LSHIFT_W'(20));
      end else if (key26 >= LSHIFT_W'(10)) begin
         key10 = DSHIFT_W'(key26 - LSHIFT_W'(10));
      end else begin
         key10 = key26[DSHIFT_W-1:0];
      end
   end

   assign lim     = (limit_ff > MAX_OUT) ? MAX_OUT : limit_ff;
   assign decrypt = (mode_ff == MODE_DECRYPT);

   // a closed message opens on its first byte item
   assign cur_ls   = msg_open_ff ? ls_ff   : key26;
   assign cur_ds   = msg_open_ff ? ds_ff   : key10;
   assign cur_wc   = msg_open_ff ? wc_ff   : '0;
   assign cur_cc   = msg_open_ff ? cc_ff   : '0;
   assign cur_full = msg_open_ff ? full_ff : 1'b0;
   assign cur_seen = msg_open_ff ? seen_ff : 1'b0;
   assign cur_fill = msg_open_ff ? fill_ff : '0;

   assign ls_next = (cur_ls == LSHIFT_W'(25)) ? '0 : cur_ls + 1'b1;
   assign ds_next = (cur_ds >= DSHIFT_W'(8)) ? cur_ds - DSHIFT_W'(8) : cur_ds + DSHIFT_W'(2);

   assign entry.ch = in_ch_ff;
   assign entry.ls = cur_ls;
   assign entry.ds = cur_ds;

   always_comb begin
      match = (in_ch_ff == MARK_FILL);
      for (int j = 0; j < HOLD_DEPTH; j++) begin
         if (hold_ff[j].ch != mark_byte(MARK_IDX_W'(j))) begin
            match = 1'b0;
         end
      end
   end

   // decrypt codes the oldest held byte with the shifts it arrived with
   assign code_ch = decrypt ? hold_ff[0].ch : in_ch_ff;
   assign code_ls = decrypt ? hold_ff[0].ls : cur_ls;
   assign code_ds = decrypt ? hold_ff[0].ds : cur_ds;

   psc_code_unit u_code (
      .ch         (code_ch),
      .ls         (code_ls),
      .ds         (code_ds),
      .decrypt    (decrypt),
      .coded_char (coded_char),
      .is_coded   (is_coded)
   );

   always_comb begin
      msg_open_in = msg_open_ff;
      ls_in       = cur_ls;
      ds_in       = cur_ds;
      wc_in       = cur_wc;
      cc_in       = cur_cc;
      full_in     = cur_full;
      seen_in     = cur_seen;
      fill_in     = cur_fill;
      hold_in     = hold_ff;
      emit        = '0;
      emit.res.status = STATUS_OK;

      if (in_kind_ff == KIND_END) begin
         msg_open_in       = 1'b0;
         emit.valid        = 1'b1;
         emit.res.is_final = 1'b1;
         if (!decrypt) begin
            if (lim < COUNT_W'(MARK_LEN)) begin
               emit.res.status = STATUS_NO_ROOM;
            end else begin
               emit.burst        = 1'b1;
               emit.final_total  = cur_cc;
               emit.res.is_final = 1'b0;
               emit.res.out_char = mark_byte('0);
            end
         end else if (lim == '0) begin
            emit.res.status = STATUS_OK;
         end else if (cur_seen) begin
            emit.res.coded_total = cur_cc;
         end else begin
            emit.res.status = STATUS_NO_MARKER;
         end
      end else begin
         msg_open_in = 1'b1;
         if (!decrypt) begin
            if (!cur_full) begin
               if (({1'b0, cur_wc} + (COUNT_W+1)'(8)) > {1'b0, lim}) begin
                  full_in = 1'b1;
               end else begin
                  emit.valid        = 1'b1;
                  emit.res.out_char = coded_char;
                  cc_in             = cur_cc + COUNT_W'(is_coded);
                  wc_in             = cur_wc + 1'b1;
                  ls_in             = ls_next;
                  ds_in             = ds_next;
               end
            end
         end else if (!cur_seen) begin
            ls_in = ls_next;
            ds_in = ds_next;
            if (cur_fill < FILL_W'(HOLD_DEPTH)) begin
               hold_in[cur_fill] = entry;
               fill_in           = cur_fill + 1'b1;
            end else if (match) begin
               seen_in = 1'b1;
            end else begin
               if (cur_wc < lim) begin
                  emit.valid        = 1'b1;
                  emit.res.out_char = coded_char;
                  cc_in             = cur_cc + COUNT_W'(is_coded);
                  wc_in             = cur_wc + 1'b1;
               end
               for (int j = 0; j < HOLD_DEPTH - 1; j++) begin
                  hold_in[j] = hold_ff[j+1];
               end
               hold_in[HOLD_DEPTH-1] = entry;
            end
         end
      end

      if (!in_advance) begin
         emit.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         msg_open_ff <= 1'b0;
         ls_ff       <= '0;
         ds_ff       <= '0;
         wc_ff       <= '0;
         cc_ff       <= '0;
         full_ff     <= 1'b0;
         seen_ff     <= 1'b0;
         fill_ff     <= '0;
      end else if (in_advance) begin
         msg_open_ff <= msg_open_in;
         ls_ff       <= ls_in;
         ds_ff       <= ds_in;
         wc_ff       <= wc_in;
         cc_ff       <= cc_in;
         full_ff     <= full_in;
         seen_ff     <= seen_in;
         fill_ff     <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_advance) begin
         hold_ff <= hold_in;
      end
   end

   psc_out_stage u_out (
      .clock           (clock),
      .reset           (reset),
      .emit            (emit),
      .take_ok         (take_ok),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_char    (rsp_out_char),
      .rsp_is_final    (rsp_is_final),
      .rsp_status      (rsp_status),
      .rsp_coded_total (rsp_coded_total)
   );

endmodule
